/* hw/rtl/htbs_pkg.sv */
package htbs_pkg;

	// default configuration
	localparam int COORD_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// angle accumulator, 1/32768 degree
	localparam int ZW           = 25;
	localparam int Z_SHIFT      = 8;
	localparam int ZR_W         = ZW - Z_SHIFT;
	localparam int ROUND_BIAS   = 128;
	localparam int FINE_QUARTER = 2949120;

	// headings and turns, 1/128 degree
	localparam int HW        = 16;
	localparam int DW        = HW + 1;
	localparam int TURN_W    = 16;
	localparam int FULL_TURN = 46080;
	localparam int HALF_TURN = 23040;

	// atan(2^-i) in 1/32768 degree, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_fine(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:  v = ZW'(1474560);
			1:  v = ZW'(870484);
			2:  v = ZW'(459940);
			3:  v = ZW'(233473);
			4:  v = ZW'(117189);
			5:  v = ZW'(58652);
			6:  v = ZW'(29333);
			7:  v = ZW'(14667);
			8:  v = ZW'(7334);
			9:  v = ZW'(3667);
			10: v = ZW'(1833);
			11: v = ZW'(917);
			12: v = ZW'(458);
			13: v = ZW'(229);
			14: v = ZW'(115);
			15: v = ZW'(57);
			16: v = ZW'(29);
			17: v = ZW'(14);
			18: v = ZW'(7);
			19: v = ZW'(4);
			20: v = ZW'(2);
			21: v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* hw/rtl/htbs_pre.sv */
module htbs_pre #(
	parameter int COORD_WIDTH   = htbs_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = htbs_pkg::CORDIC_STAGES_DEF,
	parameter int XW            = COORD_WIDTH + CORDIC_STAGES + 3
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [COORD_WIDTH-1:0]   start_x,
	input  logic signed [COORD_WIDTH-1:0]   start_y,
	input  logic signed [COORD_WIDTH-1:0]   end_x,
	input  logic signed [COORD_WIDTH-1:0]   end_y,
	output logic signed [XW-1:0]            x_s2,
	output logic signed [XW-1:0]            y_s2,
	output logic signed [htbs_pkg::ZW-1:0]  z_s2,
	output logic                            zero_s2
);
	import htbs_pkg::*;

	localparam int DXW = COORD_WIDTH + 1;

	logic signed [DXW-1:0] dx_s1, dy_s1;
	logic signed [XW-1:0]  xe, ye;

	// direction vector
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({end_x[COORD_WIDTH-1], end_x}) -
			         $signed({start_x[COORD_WIDTH-1], start_x});
			dy_s1 <= $signed({end_y[COORD_WIDTH-1], end_y}) -
			         $signed({start_y[COORD_WIDTH-1], start_y});
		end
	end

	// scale up by 2^stages
	assign xe = {{(XW-DXW-CORDIC_STAGES){dx_s1[DXW-1]}}, dx_s1, {CORDIC_STAGES{1'b0}}};
	assign ye = {{(XW-DXW-CORDIC_STAGES){dy_s1[DXW-1]}}, dy_s1, {CORDIC_STAGES{1'b0}}};

	// quarter turn into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			if (dx_s1 < 0) begin
				if (dy_s1 >= 0) begin
					x_s2 <= ye;
					y_s2 <= -xe;
					z_s2 <= ZW'(FINE_QUARTER);
				end else begin
					x_s2 <= -ye;
					y_s2 <= xe;
					z_s2 <= -ZW'(FINE_QUARTER);
				end
			end else begin
				x_s2 <= xe;
				y_s2 <= ye;
				z_s2 <= '0;
			end
		end
	end

endmodule

/* hw/rtl/htbs_cell.sv */
module htbs_cell #(
	parameter int XW  = 35,
	parameter int IDX = 0
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [XW-1:0]            x_in,
	input  logic signed [XW-1:0]            y_in,
	input  logic signed [htbs_pkg::ZW-1:0]  z_in,
	input  logic                            zero_in,
	output logic signed [XW-1:0]            x_q,
	output logic signed [XW-1:0]            y_q,
	output logic signed [htbs_pkg::ZW-1:0]  z_q,
	output logic                            zero_q
);
	import htbs_pkg::*;

	localparam logic signed [ZW-1:0] ANGLE = atan_fine(IDX);

	logic signed [XW-1:0] xs, ys;

	// floor shifts
	assign xs = x_in >>> IDX;
	assign ys = y_in >>> IDX;

	// one vectoring micro-rotation, driving y towards zero
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= zero_in;
			if (y_in > 0) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ANGLE;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ANGLE;
			end
		end
	end

endmodule

/* hw/rtl/htbs_head.sv */
module htbs_head (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [htbs_pkg::ZW-1:0]  z_in,
	input  logic                            zero_in,
	output logic [htbs_pkg::HW-1:0]         head_s2
);
	import htbs_pkg::*;

	logic signed [ZW-1:0]   zb;
	logic signed [ZR_W-1:0] zr_s1;
	logic                   zero_s1;

	assign zb = z_in + ZW'(ROUND_BIAS);

	// round to nearest 1/128 degree
	always_ff @(posedge clk) begin
		if (en) begin
			zr_s1   <= zb[ZW-1:Z_SHIFT];
			zero_s1 <= zero_in;
		end
	end

	// wrap into one full turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s1)
				head_s2 <= '0;
			else if (zr_s1 < 0)
				head_s2 <= HW'(zr_s1 + ZR_W'(FULL_TURN));
			else if (zr_s1 >= ZR_W'(FULL_TURN))
				head_s2 <= HW'(zr_s1 - ZR_W'(FULL_TURN));
			else
				head_s2 <= HW'(zr_s1);
		end
	end

endmodule

/* hw/rtl/heading_turn_between_segments_unit.sv */
// Throughput: one request per cycle while the skid entry is empty; the CORDIC
// is a row of CORDIC_STAGES registered rotation cells per heading, all
// advancing together. A two-entry output (register plus skid) lets the
// pipeline run while a result waits. arst_n clears all valid flags and
// view_mode to 0.
module heading_turn_between_segments_unit #(
	parameter int COORD_WIDTH   = htbs_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = htbs_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// curr_start_x, curr_start_y, curr_end_x, curr_end_y,
	// dest_start_x, dest_start_y, dest_end_x, dest_end_y
	input  logic [8*COORD_WIDTH-1:0]       s_tdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// turn_angle
	output logic [htbs_pkg::TURN_W-1:0]    m_tdata,
	// turn_clockwise
	output logic [0:0]                     m_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_wdata
);
	import htbs_pkg::*;

	localparam int XW  = COORD_WIDTH + CORDIC_STAGES + 3;
	localparam int NST = CORDIC_STAGES + 6;
	localparam int CW  = COORD_WIDTH;

	logic                   en;
	logic [NST-1:0]         vld_q;
	logic [1:0]             view_mode_q;

	logic signed [XW-1:0]   xc [2][CORDIC_STAGES+1];
	logic signed [XW-1:0]   yc [2][CORDIC_STAGES+1];
	logic signed [ZW-1:0]   zc [2][CORDIC_STAGES+1];
	logic                   zc_zero [2][CORDIC_STAGES+1];
	logic [HW-1:0]          head [2];

	logic signed [DW-1:0]   diff_s1;
	logic signed [DW-1:0]   fa, fb;
	logic signed [TURN_W-1:0] turn_s2;
	logic                   cw_s2;
	logic signed [TURN_W-1:0] res_turn;
	logic                   res_cw;

	logic signed [TURN_W-1:0] out_turn_q, skid_turn_q;
	logic                   out_cw_q, skid_cw_q;
	logic                   out_v_q, skid_v_q;
	logic                   take, arrive;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// view mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			view_mode_q <= '0;
		else if (cfg_we)
			view_mode_q <= cfg_wdata;
	end

	// valid flags follow the data pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end

	// two heading chains: 0 current segment, 1 destination segment
	for (genvar v = 0; v < 2; v++) begin : g_vec
		htbs_pre #(
			.COORD_WIDTH  (COORD_WIDTH),
			.CORDIC_STAGES(CORDIC_STAGES),
			.XW           (XW)
		) u_pre (
			.clk    (clk),
			.en     (en),
			.start_x(s_tdata[(4*v+0)*CW +: CW]),
			.start_y(s_tdata[(4*v+1)*CW +: CW]),
			.end_x  (s_tdata[(4*v+2)*CW +: CW]),
			.end_y  (s_tdata[(4*v+3)*CW +: CW]),
			.x_s2   (xc[v][0]),
			.y_s2   (yc[v][0]),
			.z_s2   (zc[v][0]),
			.zero_s2(zc_zero[v][0])
		);

		for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
			htbs_cell #(
				.XW (XW),
				.IDX(i)
			) u_cell (
				.clk    (clk),
				.en     (en),
				.x_in   (xc[v][i]),
				.y_in   (yc[v][i]),
				.z_in   (zc[v][i]),
				.zero_in(zc_zero[v][i]),
				.x_q    (xc[v][i+1]),
				.y_q    (yc[v][i+1]),
				.z_q    (zc[v][i+1]),
				.zero_q (zc_zero[v][i+1])
			);
		end

		htbs_head u_head (
			.clk    (clk),
			.en     (en),
			.z_in   (zc[v][CORDIC_STAGES]),
			.zero_in(zc_zero[v][CORDIC_STAGES]),
			.head_s2(head[v])
		);
	end

	// heading difference, then fold into (-180,180]
	assign fa = (diff_s1 > DW'(HALF_TURN)) ? diff_s1 - DW'(FULL_TURN) : diff_s1;
	assign fb = (fa <= -DW'(HALF_TURN)) ? fa + DW'(FULL_TURN) : fa;

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= $signed({1'b0, head[1]}) - $signed({1'b0, head[0]});
			turn_s2 <= fb[TURN_W-1:0];
			cw_s2   <= fb < 0;
		end
	end

	// mirrored views flip the sign and the direction
	assign res_turn = view_mode_q[0] ? -turn_s2 : turn_s2;
	assign res_cw   = view_mode_q[0] ? !cw_s2 : cw_s2;

	assign take   = out_v_q && m_tready;
	assign arrive = en && vld_q[NST-1];

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (arrive) begin
			if (!out_v_q || take)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_turn_q <= skid_turn_q;
				out_cw_q   <= skid_cw_q;
			end
		end else if (arrive) begin
			if (!out_v_q || take) begin
				out_turn_q <= res_turn;
				out_cw_q   <= res_cw;
			end else begin
				skid_turn_q <= res_turn;
				skid_cw_q   <= res_cw;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_turn_q;
	assign m_tuser  = out_cw_q;

endmodule
